// ===== hw/rtl/bank_mapper_with_irq_counter_macros.svh =====
// ----------------------------------------------------------------------------
// bank mapper assertion macros
// shared macros for concurrent checks on the mapper ports
// ----------------------------------------------------------------------------
`ifndef BANK_MAPPER_WITH_IRQ_COUNTER_MACROS_SVH
`define BANK_MAPPER_WITH_IRQ_COUNTER_MACROS_SVH

// check sampled on the clock, switched off while reset is held
`define BMIC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check sampled on the clock, live during reset too
`define BMIC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bmic_pkg.sv =====
// ----------------------------------------------------------------------------
// bmic_pkg
// shared types and constants of the bank mapper with irq counter
// ----------------------------------------------------------------------------
`default_nettype none

package bmic_pkg;

    localparam int OPCODE_W    = 2;
    localparam int CPU_ADDR_W  = 16;
    localparam int DATA_W      = 8;
    localparam int PPU_ADDR_W  = 13;
    localparam int BANK_W      = 16;
    localparam int KIND_W      = 2;
    localparam int MIRROR_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int CHR_SLOTS_DEF = 8;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PRG   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CHR   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRG_RAM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRG_ROM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHR     = 2'd3;

    localparam logic [MIRROR_W-1:0] MIRROR_VERT   = 2'd0;
    localparam logic [MIRROR_W-1:0] MIRROR_HORZ   = 2'd1;
    localparam logic [MIRROR_W-1:0] MIRROR_SINGLE = 2'd2;
    localparam logic [MIRROR_W-1:0] MIRROR_BAD    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_AND_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OR_BITS  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] AND_MASK_RST = 16'h00FF;
    localparam logic [CFG_DATA_W-1:0] OR_BITS_RST  = 16'h0000;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/bmic_in_if.sv =====
// ----------------------------------------------------------------------------
// bmic_in_if
// input channel of the mapper: one bus operation per word
// ----------------------------------------------------------------------------
`default_nettype none

interface bmic_in_if;
    import bmic_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [CPU_ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0]     write_data;
    logic [PPU_ADDR_W-1:0] ppu_address;

    modport source (output valid, opcode, cpu_address, write_data, ppu_address, input ready);
    modport sink   (input valid, opcode, cpu_address, write_data, ppu_address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmic_out_if.sv =====
// ----------------------------------------------------------------------------
// bmic_out_if
// result channel of the mapper: one lookup result per word
// ----------------------------------------------------------------------------
`default_nettype none

interface bmic_out_if;
    import bmic_pkg::*;

    logic                valid;
    logic                ready;
    logic                irq_asserted;
    logic [BANK_W-1:0]   mapped_bank;
    logic [KIND_W-1:0]   map_kind;
    logic [MIRROR_W-1:0] mirror_mode;

    modport source (output valid, irq_asserted, mapped_bank, map_kind, mirror_mode, input ready);
    modport sink   (input valid, irq_asserted, mapped_bank, map_kind, mirror_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bank_mapper_with_irq_counter.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_irq_counter
// cartridge bank mapper with a 16-bit cpu cycle irq down-counter
//
//   channel   dir  handshake         word
//   i_item    in   valid / ready     opcode, cpu_address, write_data, ppu_address
//   o_result  out  valid / ready     irq_asserted, mapped_bank, map_kind, mirror_mode
//   i_cfg_*   in   write enable      index, 16-bit data, no read-back
//
// each word is captured as it is taken in the idle state; in the execute
// state the datapath updates the mapper state and loads the result register.
// a word waits in the execute state while the result register is full and
// not taken; ready stays low while it waits.
// synchronous reset sets all mapper state to its power-on values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_irq_counter #(
    parameter int CHR_SLOTS = bmic_pkg::CHR_SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bmic_in_if.sink                              i_item,
    bmic_out_if.source                           o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [bmic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bmic_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bmic_pkg::*;

    t_cmd cmd;

    bmic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    bmic_dp #(
        .CHR_SLOTS (CHR_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_item.opcode),
        .i_cpu_address  (i_item.cpu_address),
        .i_write_data   (i_item.write_data),
        .i_ppu_address  (i_item.ppu_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_irq_asserted (o_result.irq_asserted),
        .o_mapped_bank  (o_result.mapped_bank),
        .o_map_kind     (o_result.map_kind),
        .o_mirror_mode  (o_result.mirror_mode)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bmic_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmic_ctrl
// controller: takes a word, runs it once the result register is free
// ----------------------------------------------------------------------------
`default_nettype none

module bmic_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bmic_pkg::t_cmd     o_cmd
);
    import bmic_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/bmic_dp.sv =====
// ----------------------------------------------------------------------------
// bmic_dp
// datapath: bank registers, irq down-counter, lookup and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bmic_dp #(
    parameter int CHR_SLOTS = bmic_pkg::CHR_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bmic_pkg::t_cmd                    i_cmd,
    input  wire logic [bmic_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic [bmic_pkg::CPU_ADDR_W-1:0]   i_cpu_address,
    input  wire logic [bmic_pkg::DATA_W-1:0]       i_write_data,
    input  wire logic [bmic_pkg::PPU_ADDR_W-1:0]   i_ppu_address,
    input  wire logic                              i_cfg_we,
    input  wire logic [bmic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bmic_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                                   o_irq_asserted,
    output logic [bmic_pkg::BANK_W-1:0]            o_mapped_bank,
    output logic [bmic_pkg::KIND_W-1:0]            o_map_kind,
    output logic [bmic_pkg::MIRROR_W-1:0]          o_mirror_mode
);
    import bmic_pkg::*;

    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    localparam logic [3:0] PAGE_PRG0 = 4'h8;
    localparam logic [3:0] PAGE_CTRL = 4'h9;
    localparam logic [3:0] PAGE_PRG1 = 4'hA;
    localparam logic [3:0] PAGE_CHR  = 4'hB;

    localparam logic [2:0] SUB_INVERT  = 3'd0;
    localparam logic [2:0] SUB_MIRROR  = 3'd1;
    localparam logic [2:0] SUB_IRQ_EN  = 3'd3;
    localparam logic [2:0] SUB_RELOAD  = 3'd4;
    localparam logic [2:0] SUB_LATCH_H = 3'd5;
    localparam logic [2:0] SUB_LATCH_L = 3'd6;

    localparam logic [2:0] SLOT_RAM  = 3'd3;
    localparam logic [2:0] SLOT_8000 = 3'd4;
    localparam logic [2:0] SLOT_A000 = 3'd5;
    localparam logic [2:0] SLOT_C000 = 3'd6;

    localparam logic [DATA_W-1:0] BANK_FE = 8'hFE;
    localparam logic [DATA_W-1:0] BANK_FF = 8'hFF;

    // captured word
    logic [OPCODE_W-1:0]   r_opcode;
    logic [CPU_ADDR_W-1:0] r_cpu_address;
    logic [DATA_W-1:0]     r_write_data;
    logic [PPU_ADDR_W-1:0] r_ppu_address;

    // mapper state
    logic [CFG_DATA_W-1:0] r_and_mask;
    logic [CFG_DATA_W-1:0] r_or_bits;
    logic                  r_invert,  n_invert;
    logic [DATA_W-1:0]     r_prg0,    n_prg0;
    logic [DATA_W-1:0]     r_prg1,    n_prg1;
    logic [DATA_W-1:0]     r_chr [CHR_SLOTS];
    logic [1:0]            r_mirror_sel, n_mirror_sel;
    logic                  r_irq_en,  n_irq_en;
    logic [15:0]           r_counter, n_counter;
    logic [15:0]           r_latch,   n_latch;
    logic                  r_irq_line, n_irq_line;

    // result register
    logic                r_res_irq;
    logic [BANK_W-1:0]   r_res_bank;
    logic [KIND_W-1:0]   r_res_kind;
    logic [MIRROR_W-1:0] r_res_mirror;

    logic                 chr_we;
    logic [CHR_IDX_W-1:0] chr_widx;
    logic [CHR_IDX_W-1:0] chr_ridx;
    logic [DATA_W-1:0]    raw_bank;
    logic [15:0]          cnt_dec;
    logic [2:0]           prg_slot;
    logic [BANK_W-1:0]    res_bank;
    logic [KIND_W-1:0]    res_kind;
    logic [MIRROR_W-1:0]  res_mirror;

    function automatic logic [BANK_W-1:0] apply_mask(
        input logic [DATA_W-1:0]     bank,
        input logic [CFG_DATA_W-1:0] and_mask,
        input logic [CFG_DATA_W-1:0] or_bits
    );
        return ({{(BANK_W-DATA_W){1'b0}}, bank} & and_mask) | or_bits;
    endfunction

    assign chr_widx = r_cpu_address[CHR_IDX_W-1:0];
    assign chr_ridx = r_ppu_address[10 +: CHR_IDX_W];
    assign cnt_dec  = r_counter - 16'd1;
    assign prg_slot = r_cpu_address[15:13];

    // state update of the held word
    always_comb begin
        n_invert     = r_invert;
        n_prg0       = r_prg0;
        n_prg1       = r_prg1;
        n_mirror_sel = r_mirror_sel;
        n_irq_en     = r_irq_en;
        n_counter    = r_counter;
        n_latch      = r_latch;
        n_irq_line   = r_irq_line;
        chr_we       = 1'b0;
        case (r_opcode)
            OP_WRITE: begin
                case (r_cpu_address[15:12])
                    PAGE_PRG0: n_prg0 = r_write_data;
                    PAGE_PRG1: n_prg1 = r_write_data;
                    PAGE_CHR:  chr_we = 1'b1;
                    PAGE_CTRL: begin
                        case (r_cpu_address[2:0])
                            SUB_INVERT:  n_invert     = r_write_data[7];
                            SUB_MIRROR:  n_mirror_sel = r_write_data[7:6];
                            SUB_IRQ_EN: begin
                                n_irq_en   = r_write_data[7];
                                n_irq_line = 1'b0;
                            end
                            SUB_RELOAD: begin
                                n_counter  = r_latch;
                                n_irq_line = 1'b0;
                            end
                            SUB_LATCH_H: n_latch = {r_write_data, r_latch[7:0]};
                            SUB_LATCH_L: n_latch = {r_latch[15:8], r_write_data};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_irq_en) begin
                    n_counter = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        n_irq_line = 1'b1;
                        n_irq_en   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // lookup
    always_comb begin
        raw_bank = '0;
        res_kind = KIND_NONE;
        case (r_opcode)
            OP_PRG: begin
                if (prg_slot >= SLOT_RAM) begin
                    res_kind = KIND_PRG_ROM;
                    case (prg_slot)
                        SLOT_RAM: begin
                            raw_bank = '0;
                            res_kind = KIND_PRG_RAM;
                        end
                        SLOT_8000: raw_bank = r_invert ? BANK_FE : r_prg0;
                        SLOT_A000: raw_bank = r_prg1;
                        SLOT_C000: raw_bank = r_invert ? r_prg0 : BANK_FE;
                        default:   raw_bank = BANK_FF;
                    endcase
                end
            end
            OP_CHR: begin
                raw_bank = r_chr[chr_ridx];
                res_kind = KIND_CHR;
            end
            default: ;
        endcase
    end

    assign res_bank = (res_kind == KIND_NONE) ? '0 : apply_mask(raw_bank, r_and_mask, r_or_bits);

    always_comb begin
        case (n_mirror_sel)
            2'd0:    res_mirror = MIRROR_VERT;
            2'd2:    res_mirror = MIRROR_HORZ;
            default: res_mirror = MIRROR_SINGLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode      <= i_opcode;
            r_cpu_address <= i_cpu_address;
            r_write_data  <= i_write_data;
            r_ppu_address <= i_ppu_address;
        end
        if (i_cmd.commit) begin
            r_res_irq    <= n_irq_line;
            r_res_bank   <= res_bank;
            r_res_kind   <= res_kind;
            r_res_mirror <= res_mirror;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_and_mask <= AND_MASK_RST;
            r_or_bits  <= OR_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AND_MASK: r_and_mask <= i_cfg_wdata;
                CFG_OR_BITS:  r_or_bits  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert     <= 1'b0;
            r_prg0       <= 8'd0;
            r_prg1       <= 8'd1;
            r_mirror_sel <= 2'd0;
            r_irq_en     <= 1'b0;
            r_counter    <= 16'd0;
            r_latch      <= 16'd0;
            r_irq_line   <= 1'b0;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr[i] <= DATA_W'(i);
            end
        end else if (i_cmd.commit) begin
            r_invert     <= n_invert;
            r_prg0       <= n_prg0;
            r_prg1       <= n_prg1;
            r_mirror_sel <= n_mirror_sel;
            r_irq_en     <= n_irq_en;
            r_counter    <= n_counter;
            r_latch      <= n_latch;
            r_irq_line   <= n_irq_line;
            if (chr_we) begin
                r_chr[chr_widx] <= r_write_data;
            end
        end
    end

    assign o_irq_asserted = r_res_irq;
    assign o_mapped_bank  = r_res_bank;
    assign o_map_kind     = r_res_kind;
    assign o_mirror_mode  = r_res_mirror;

endmodule

`default_nettype wire

// ===== hw/rtl/bmic_checker.sv =====
// ----------------------------------------------------------------------------
// bmic_checker
// port-level checks of the bank mapper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_mapper_with_irq_counter_macros.svh"

module bmic_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [bmic_pkg::BANK_W-1:0]   i_mapped_bank,
    input  wire logic [bmic_pkg::KIND_W-1:0]   i_map_kind,
    input  wire logic [bmic_pkg::MIRROR_W-1:0] i_mirror_mode
);
    import bmic_pkg::*;

    `BMIC_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `BMIC_ASSERT_CLK(a_one_word_at_a_time, i_in_valid && i_in_ready |=> !i_in_ready, "word taken while one is in flight")

    `BMIC_ASSERT_CLK(a_unmapped_zero, i_out_valid && (i_map_kind == KIND_NONE) |-> i_mapped_bank == '0, "unmapped result with nonzero bank")

    `BMIC_ASSERT_CLK(a_mirror_code, i_out_valid |-> i_mirror_mode != MIRROR_BAD, "mirror mode out of range")

    `BMIC_ASSERT_CLK(a_stall_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mapped_bank), "stalled result changed")

endmodule

bind bank_mapper_with_irq_counter bmic_checker u_bmic_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_mapped_bank (o_result.mapped_bank),
    .i_map_kind    (o_result.map_kind),
    .i_mirror_mode (o_result.mirror_mode)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// bank mapper with irq counter testbench
// drives bus words into the mapper through the valid/ready input channel,
// predicts every result word from a private copy of the mapper state and
// compares each accepted result field by field. covers the power-on map,
// bank and control writes, the irq down-counter, mask settings, random
// traffic with idle bursts on both sides and a long result-side stall.
// ----------------------------------------------------------------------------
module tb;
    import bmic_pkg::*;

    localparam int RUN_LIMIT      = 400000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int SHOW_LIMIT     = 10;

    localparam logic [3:0] PAGE_PRG0 = 4'h8;
    localparam logic [3:0] PAGE_CTRL = 4'h9;
    localparam logic [3:0] PAGE_PRG1 = 4'hA;
    localparam logic [3:0] PAGE_CHR  = 4'hB;

    localparam logic [2:0] SUB_INVERT   = 3'd0;
    localparam logic [2:0] SUB_MIRROR   = 3'd1;
    localparam logic [2:0] SUB_IRQ_CTRL = 3'd3;
    localparam logic [2:0] SUB_RELOAD   = 3'd4;
    localparam logic [2:0] SUB_LATCH_HI = 3'd5;
    localparam logic [2:0] SUB_LATCH_LO = 3'd6;

    localparam logic [2:0] SLOT_RAM  = 3'd3;
    localparam logic [2:0] SLOT_8000 = 3'd4;
    localparam logic [2:0] SLOT_A000 = 3'd5;
    localparam logic [2:0] SLOT_C000 = 3'd6;

    localparam logic [7:0] BANK_FIXED_FE = 8'hFE;
    localparam logic [7:0] BANK_FIXED_FF = 8'hFF;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [CPU_ADDR_W-1:0] cpu_address;
        logic [DATA_W-1:0]     write_data;
        logic [PPU_ADDR_W-1:0] ppu_address;
    } bus_word_t;

    typedef struct packed {
        logic                irq;
        logic [BANK_W-1:0]   bank;
        logic [KIND_W-1:0]   kind;
        logic [MIRROR_W-1:0] mirror;
    } map_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    bmic_in_if  item_ch ();
    bmic_out_if result_ch ();

    bank_mapper_with_irq_counter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mapper state as predicted
    logic [15:0] and_mask_q;
    logic [15:0] or_bits_q;
    logic        invert_q;
    logic [7:0]  prg_bank_q [2];
    logic [7:0]  chr_bank_q [CHR_SLOTS_DEF];
    logic [1:0]  mirror_q;
    logic        irq_en_q;
    logic [15:0] count_q;
    logic [15:0] latch_q;
    logic        irq_q;

    map_result_t pending_results [$];

    int  fail_count;
    int  mismatches;
    int  cycle_count;
    int  words_sent;
    int  op_count [4];
    int  irq_raise_count;
    int  mask_settings;
    bit  quiet;
    bit  tx_gaps_on;
    bit  hold_request;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [15:0] masked_bank(input logic [15:0] b);
        return (b & and_mask_q) | or_bits_q;
    endfunction

    function automatic void mapper_reset();
        and_mask_q    = AND_MASK_RST;
        or_bits_q     = OR_BITS_RST;
        invert_q      = 1'b0;
        prg_bank_q[0] = 8'd0;
        prg_bank_q[1] = 8'd1;
        for (int i = 0; i < CHR_SLOTS_DEF; i++) chr_bank_q[i] = 8'(i);
        mirror_q      = 2'd0;
        irq_en_q      = 1'b0;
        count_q       = 16'd0;
        latch_q       = 16'd0;
        irq_q         = 1'b0;
    endfunction

    function automatic map_result_t mapper_predict(input bus_word_t w);
        map_result_t r;
        logic [2:0]  slot;
        logic [7:0]  b;
        r = '0;
        case (w.opcode)
            OP_WRITE: begin
                case (w.cpu_address[15:12])
                    PAGE_PRG0: prg_bank_q[0] = w.write_data;
                    PAGE_PRG1: prg_bank_q[1] = w.write_data;
                    PAGE_CHR:  chr_bank_q[w.cpu_address[2:0]] = w.write_data;
                    PAGE_CTRL: begin
                        case (w.cpu_address[2:0])
                            SUB_INVERT:   invert_q = w.write_data[7];
                            SUB_MIRROR:   mirror_q = w.write_data[7:6];
                            SUB_IRQ_CTRL: begin
                                irq_en_q = w.write_data[7];
                                irq_q    = 1'b0;
                            end
                            SUB_RELOAD: begin
                                count_q = latch_q;
                                irq_q   = 1'b0;
                            end
                            SUB_LATCH_HI: latch_q[15:8] = w.write_data;
                            SUB_LATCH_LO: latch_q[7:0]  = w.write_data;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (irq_en_q) begin
                    count_q = count_q - 16'd1;
                    if (count_q == 16'd0) begin
                        irq_q    = 1'b1;
                        irq_en_q = 1'b0;
                        irq_raise_count++;
                    end
                end
            end
            OP_PRG: begin
                slot = w.cpu_address[15:13];
                if (slot == SLOT_RAM) begin
                    r.bank = masked_bank(16'd0);
                    r.kind = KIND_PRG_RAM;
                end else if (slot > SLOT_RAM) begin
                    case (slot)
                        SLOT_8000: b = invert_q ? BANK_FIXED_FE : prg_bank_q[0];
                        SLOT_A000: b = prg_bank_q[1];
                        SLOT_C000: b = invert_q ? prg_bank_q[0] : BANK_FIXED_FE;
                        default:   b = BANK_FIXED_FF;
                    endcase
                    r.bank = masked_bank({8'h00, b});
                    r.kind = KIND_PRG_ROM;
                end
            end
            default: begin
                r.bank = masked_bank({8'h00, chr_bank_q[w.ppu_address[12:10]]});
                r.kind = KIND_CHR;
            end
        endcase
        r.irq = irq_q;
        if (mirror_q == 2'd0)      r.mirror = MIRROR_VERT;
        else if (mirror_q == 2'd2) r.mirror = MIRROR_HORZ;
        else                       r.mirror = MIRROR_SINGLE;
        return r;
    endfunction

    // predict on every accepted bus word
    always @(posedge i_clk) begin : bus_monitor
        bus_word_t w;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            w.opcode      = item_ch.opcode;
            w.cpu_address = item_ch.cpu_address;
            w.write_data  = item_ch.write_data;
            w.ppu_address = item_ch.ppu_address;
            op_count[w.opcode]++;
            pending_results.push_back(mapper_predict(w));
        end
    end

    always @(posedge i_clk) begin : result_check
        map_result_t got;
        map_result_t want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.irq    = result_ch.irq_asserted;
            got.bank   = result_ch.mapped_bank;
            got.kind   = result_ch.map_kind;
            got.mirror = result_ch.mirror_mode;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (mismatches < SHOW_LIMIT)
                    $display("unexpected result word irq=%0b bank=%h kind=%0d mirror=%0d",
                             got.irq, got.bank, got.kind, got.mirror);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.irq !== want.irq || got.bank !== want.bank ||
                    got.kind !== want.kind || got.mirror !== want.mirror) begin
                    fail_count++;
                    if (mismatches < SHOW_LIMIT)
                        $display({"result mismatch: expected irq=%0b bank=%h kind=%0d ",
                                  "mirror=%0d, got irq=%0b bank=%h kind=%0d mirror=%0d"},
                                 want.irq, want.bank, want.kind, want.mirror,
                                 got.irq, got.bank, got.kind, got.mirror);
                    mismatches++;
                end
            end
        end
    end

    // result side pacing
    initial begin : result_pacing
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("bank_mapper_with_irq_counter regression: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [OPCODE_W-1:0] op,
                             input logic [CPU_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data,
                             input logic [PPU_ADDR_W-1:0] paddr);
        if (!quiet && tx_gaps_on && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.cpu_address <= addr;
        item_ch.write_data  <= data;
        item_ch.ppu_address <= paddr;
        do @(posedge i_clk); while (!item_ch.ready);
        words_sent++;
    endtask

    task automatic send_ctrl(input logic [2:0] sub, input logic [DATA_W-1:0] data);
        logic [8:0] mid;
        mid = 9'($urandom_range(0, 511));
        send_word(OP_WRITE, {PAGE_CTRL, mid, sub}, data, 13'($urandom_range(0, 8191)));
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  13'($urandom_range(0, 8191)));
    endtask

    task automatic send_random_word();
        logic [OPCODE_W-1:0]   op;
        logic [CPU_ADDR_W-1:0] addr;
        op   = OPCODE_W'($urandom_range(0, 3));
        addr = 16'($urandom_range(0, 65535));
        if (op == OP_WRITE && $urandom_range(0, 3) != 0)
            addr[15:12] = PAGE_PRG0 + 4'($urandom_range(0, 3));
        send_word(op, addr, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
    endtask

    // latch, reload, enable, then tick toward zero with some noise mixed in
    task automatic run_irq_sequence();
        int ticks;
        ticks = $urandom_range(0, 12);
        send_ctrl(SUB_LATCH_HI, ($urandom_range(0, 5) == 0) ?
                  8'($urandom_range(0, 255)) : 8'h00);
        send_ctrl(SUB_LATCH_LO, 8'(ticks));
        send_ctrl(SUB_RELOAD, 8'($urandom_range(0, 255)));
        send_ctrl(SUB_IRQ_CTRL, {1'b1, 7'($urandom_range(0, 127))});
        repeat (ticks + $urandom_range(0, 3)) begin
            if ($urandom_range(0, 4) == 0) send_random_word();
            send_tick();
        end
        send_ctrl(SUB_IRQ_CTRL, 8'($urandom_range(0, 255)));
    endtask

    // let the current edge pass first so the word accepted on it is queued
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_masks(input logic [15:0] and_val, input logic [15:0] or_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AND_MASK;
        i_cfg_wdata <= and_val;
        @(posedge i_clk);
        and_mask_q = and_val;
        i_cfg_index <= CFG_OR_BITS;
        i_cfg_wdata <= or_val;
        @(posedge i_clk);
        or_bits_q = or_val;
        i_cfg_we <= 1'b0;
        mask_settings++;
    endtask

    task automatic test_power_on_map();
        send_word(OP_PRG, 16'h0000, 8'h00, 13'h0000);
        send_word(OP_PRG, 16'h6000, 8'h00, 13'h0000);
        send_word(OP_PRG, 16'h8000, 8'h00, 13'h0000);
        send_word(OP_PRG, 16'hC000, 8'h00, 13'h0000);
        send_word(OP_PRG, 16'hFFFF, 8'hFF, 13'h1FFF);
        send_word(OP_CHR, 16'h0000, 8'h00, 13'h1FFF);
    endtask

    task automatic test_bank_registers();
        send_word(OP_WRITE, 16'h8000, 8'hFF, 13'h0000);
        send_word(OP_WRITE, 16'hAFFF, 8'h80, 13'h0000);
        send_word(OP_WRITE, 16'hB007, 8'hFF, 13'h0000);
        send_ctrl(SUB_INVERT, 8'h80);
        send_word(OP_PRG, 16'hC123, 8'h00, 13'h0000);
        send_word(OP_CHR, 16'h0000, 8'h00, 13'h1C00);
        send_word(OP_WRITE, 16'h9002, 8'hFF, 13'h0000);
        send_word(OP_WRITE, 16'h9007, 8'hFF, 13'h0000);
        send_word(OP_WRITE, 16'h7FFF, 8'hFF, 13'h0000);
        send_ctrl(SUB_MIRROR, 8'h40);
        send_ctrl(SUB_MIRROR, 8'h80);
    endtask

    task automatic test_irq_counter();
        send_ctrl(SUB_LATCH_HI, 8'h00);
        send_ctrl(SUB_LATCH_LO, 8'h02);
        send_ctrl(SUB_RELOAD, 8'h00);
        send_ctrl(SUB_IRQ_CTRL, 8'h80);
        repeat (3) send_tick();
        send_ctrl(SUB_IRQ_CTRL, 8'h80);
        send_tick();
        send_ctrl(SUB_IRQ_CTRL, 8'h00);
    endtask

    task automatic test_random_traffic(input logic [15:0] and_val,
                                       input logic [15:0] or_val, input int n);
        int target;
        wait_drained();
        write_masks(and_val, or_val);
        target = words_sent + n;
        while (words_sent < target) begin
            if ($urandom_range(0, 2) == 0) run_irq_sequence();
            else send_random_word();
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_random_word();
        tx_gaps_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_AND_MASK;
        i_cfg_wdata         = '0;
        item_ch.valid       = 1'b0;
        item_ch.opcode      = OP_WRITE;
        item_ch.cpu_address = '0;
        item_ch.write_data  = '0;
        item_ch.ppu_address = '0;
        fail_count          = 0;
        mismatches          = 0;
        cycle_count         = 0;
        words_sent          = 0;
        irq_raise_count     = 0;
        mask_settings       = 0;
        op_count            = '{default: 0};
        quiet               = 1'b0;
        tx_gaps_on          = 1'b1;
        hold_request        = 1'b0;
        mapper_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_map();
        test_bank_registers();
        test_irq_counter();
        test_random_traffic(16'hFFFF, 16'h0000, 150);
        test_random_traffic(16'h0000, 16'hFFFF, 100);
        test_random_traffic(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 150);
        test_backpressure();
        quiet = 1'b1;
        test_random_traffic(AND_MASK_RST, OR_BITS_RST, 150);

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("covered %0d words: %0d writes, %0d ticks, %0d prg and %0d chr lookups",
                 words_sent, op_count[OP_WRITE], op_count[OP_TICK], op_count[OP_PRG],
                 op_count[OP_CHR]);
        $display("irq raised %0d times over %0d mask settings, %0d failures",
                 irq_raise_count, mask_settings, fail_count);
        if (fail_count == 0)
            $display("bank_mapper_with_irq_counter regression: pass");
        else
            $display("bank_mapper_with_irq_counter regression: fail");
        $finish;
    end
endmodule
